// ===== hdl/u2u8_pkg.sv =====
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

  // Queue depth between the front and the back
  localparam int unsigned QueueDepthDef = 2;

  // Most bytes one code unit can cause: a held high surrogate alone plus a BMP unit
  localparam int unsigned JobBytes = 6;

  // Surrogate ranges
  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;

  // Encoding limits and lead byte marks
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Max1Byte  = 21'h0007F;
  localparam logic [20:0] Max2Byte  = 21'h007FF;
  localparam logic [20:0] Max3Byte  = 21'h0FFFF;
  localparam logic [7:0]  Lead2     = 8'hC0;
  localparam logic [7:0]  Lead3     = 8'hE0;
  localparam logic [7:0]  Lead4     = 8'hF0;
  localparam logic [7:0]  ContMark  = 8'h80;

  typedef logic [7:0] octet_t;

  // One encoded code point: up to four bytes and their number
  typedef struct packed {
    octet_t [3:0] b;
    logic [2:0]   len;
  } enc_t;

  // One unit of work for the back: the bytes an accepted code unit causes
  typedef struct packed {
    octet_t [JobBytes-1:0] bytes;
    logic [2:0]            count;
    logic                  fin;
  } job_t;

  // Encode one code point into UTF-8 bytes, first byte in b[0]
  function automatic enc_t encode_cp(logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= Max1Byte) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp <= Max2Byte) begin
      e.b[0] = Lead2 | {3'b000, cp[10:6]};
      e.b[1] = ContMark | {2'b00, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp <= Max3Byte) begin
      e.b[0] = Lead3 | {4'b0000, cp[15:12]};
      e.b[1] = ContMark | {2'b00, cp[11:6]};
      e.b[2] = ContMark | {2'b00, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = Lead4 | {5'b00000, cp[20:18]};
      e.b[1] = ContMark | {2'b00, cp[17:12]};
      e.b[2] = ContMark | {2'b00, cp[11:6]};
      e.b[3] = ContMark | {2'b00, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== hdl/u2u8_front.sv =====
// Front of the transcoder: accepts code units, pairs surrogates and builds byte jobs.
module u2u8_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     code_unit_i,
  input  logic            final_unit_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output u2u8_pkg::job_t  push_data_o
);
  import u2u8_pkg::*;

  logic [9:0] held_high_q, held_high_d;
  logic       held_valid_q, held_valid_d;
  logic       is_high, is_low, accept;
  enc_t       enc_held, enc_cur, enc_pair;
  job_t       job;

  // Classify the incoming unit
  assign is_high = code_unit_i inside {[HighFirst:HighLast]};
  assign is_low  = code_unit_i inside {[LowFirst:LowLast]};
  assign accept  = in_valid_i && push_ready_i;

  // Encode the three candidate code points
  assign enc_pair = encode_cp(SuppBase + {1'b0, held_high_q, code_unit_i[9:0]});
  assign enc_held = encode_cp({5'b00000, HighFirst | {6'b000000, held_high_q}});
  assign enc_cur  = encode_cp({5'b00000, code_unit_i});

  // Build the job and the next held state
  always_comb begin
    job          = '0;
    job.fin      = final_unit_i;
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    if (held_valid_q && is_low) begin
      job.bytes[3:0] = enc_pair.b;
      job.count      = enc_pair.len;
      held_valid_d   = 1'b0;
      held_high_d    = '0;
    end else begin
      if (held_valid_q) begin
        job.bytes[2:0] = enc_held.b[2:0];
        job.count      = 3'd3;
        held_valid_d   = 1'b0;
        held_high_d    = '0;
      end
      if (is_high && !final_unit_i) begin
        held_high_d  = code_unit_i[9:0];
        held_valid_d = 1'b1;
      end else if (held_valid_q) begin
        job.bytes[JobBytes-1:3] = enc_cur.b[2:0];
        job.count               = 3'd3 + enc_cur.len;
      end else begin
        job.bytes[3:0] = enc_cur.b;
        job.count      = enc_cur.len;
      end
    end
  end

  // Hold surrogate state across beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_high_q  <= '0;
      held_valid_q <= 1'b0;
    end else if (accept) begin
      held_high_q  <= held_high_d;
      held_valid_q <= held_valid_d;
    end
  end

  // Push only jobs that carry bytes
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (job.count != 3'd0);
  assign push_data_o  = job;

endmodule

// ===== hdl/u2u8_queue.sv =====
// Short job queue between the front and the back of the transcoder.
module u2u8_queue #(
  parameter int unsigned Depth = u2u8_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  u2u8_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output u2u8_pkg::job_t  pop_data_o
);
  import u2u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Hold pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/u2u8_back.sv =====
// Back of the transcoder: serializes job bytes onto the output register.
module u2u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  u2u8_pkg::job_t  pop_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_end_o
);
  import u2u8_pkg::*;

  job_t       job_q;
  logic       job_valid_q;
  logic [2:0] idx_q;
  logic       out_valid_q, run_last_q, string_end_q;
  octet_t     out_byte_q;
  logic       adv, last, take;

  // Step one byte whenever the output register is free
  assign adv         = job_valid_q && (!out_valid_q || out_ready_i);
  assign last        = (idx_q == job_q.count - 3'd1);
  assign pop_ready_o = !job_valid_q || (adv && last);
  assign take        = pop_valid_i && pop_ready_o;

  // Hold the current job and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_ready_o) begin
      job_valid_q <= pop_valid_i;
      idx_q       <= '0;
    end else if (adv) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= pop_data_i;
    end
  end

  // Drive the output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q   <= job_q.bytes[idx_q];
      run_last_q   <= last;
      string_end_q <= last && job_q.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// Accepts one UTF-16 code unit per beat and emits its UTF-8 bytes one per beat.
// A high surrogate is held until the next unit: a following low surrogate makes
// a 4-byte supplementary character, anything else (or the end of the string)
// sends the held surrogate alone as 3 bytes before the current unit. Each
// accepted unit turns into 0 to 6 output bytes; the output side delivers one
// byte per cycle while the receiver is ready and jobs are waiting; a BMP unit
// causes 1 to 3 bytes, a pair 4 over its two units. The front accepts a unit every
// cycle while the job queue (QueueDepth entries) has room; a unit that causes
// no byte passes without using queue space, but waits for room like any other.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = u2u8_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_end_o
);
  import u2u8_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  // Classify units and build jobs
  u2u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple front and back
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Serialize bytes
  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

// ===== tb/sv/tb_utf16_to_utf8_transcoder.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder with random flow control.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;
  import u2u8_pkg::*;

  // One UTF-16 code unit waiting to be offered
  typedef struct {
    logic [15:0] unit;
    logic        fin;
  } utf16_beat_t;

  // One UTF-8 byte we expect on the output side
  typedef struct {
    octet_t data;
    logic   run_last;
    logic   string_end;
  } utf8_beat_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_unit_i  = '0;
  logic        final_unit_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        string_end_o;

  utf16_beat_t utf16_backlog[$];
  utf8_beat_t  utf8_expect[$];
  octet_t      unit_bytes[$];

  // Predictor state: the high surrogate held back from the previous unit
  logic        pend_vld  = 1'b0;
  logic [9:0]  pend_bits = '0;

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int          units_taken  = 0;
  int          err_cnt      = 0;
  int          hold_at      = -1;
  bit          hold_done    = 1'b0;
  int          hold_left    = 0;

  utf16_to_utf8_transcoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Add one byte to the tail of unit_bytes
  function automatic void add_byte(input octet_t v);
    unit_bytes = {unit_bytes, v};
  endfunction

  // Append the UTF-8 form of one code point to unit_bytes
  function automatic void append_utf8(input logic [20:0] cp);
    if (cp <= Max1Byte) begin
      add_byte(cp[7:0]);
    end else if (cp <= Max2Byte) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp <= Max3Byte) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Work out the bytes one accepted code unit causes and queue them
  function automatic void transcode_unit(input logic [15:0] u, input logic fin);
    logic       is_high;
    logic       is_low;
    utf8_beat_t b;
    is_high = (u >= HighFirst) && (u <= HighLast);
    is_low  = (u >= LowFirst) && (u <= LowLast);
    unit_bytes.delete();
    if (pend_vld && is_low) begin
      append_utf8(SuppBase + {1'b0, pend_bits, u[9:0]});
      pend_vld  = 1'b0;
      pend_bits = '0;
    end else begin
      // Flush a held high surrogate that found no partner
      if (pend_vld) begin
        append_utf8({5'd0, 6'b110110, pend_bits});
        pend_vld  = 1'b0;
        pend_bits = '0;
      end
      if (is_high && !fin) begin
        pend_bits = u[9:0];
        pend_vld  = 1'b1;
      end else begin
        append_utf8({5'd0, u});
      end
    end
    foreach (unit_bytes[k]) begin
      b.data       = unit_bytes[k];
      b.run_last   = (k == unit_bytes.size() - 1);
      b.string_end = b.run_last && fin;
      utf8_expect  = {utf8_expect, b};
    end
  endfunction

  task automatic queue_unit(input logic [15:0] u, input logic fin);
    utf16_beat_t t;
    t.unit = u;
    t.fin  = fin;
    utf16_backlog = {utf16_backlog, t};
  endtask

  // Queue random units, mostly well-formed text with some noise
  task automatic queue_random(input int count);
    int          pushed;
    int          kind;
    logic [15:0] u;
    logic        fin;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(99);
      fin  = ($urandom_range(9) == 0);
      if (kind < 15) begin
        queue_unit(16'($urandom_range(16'h007F)), fin);
        pushed++;
      end else if (kind < 30) begin
        queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), fin);
        pushed++;
      end else if (kind < 50) begin
        do u = 16'($urandom_range(16'hFFFF, 16'h0800));
        while (u >= HighFirst && u <= LowLast);
        queue_unit(u, fin);
        pushed++;
      end else if (kind < 75) begin
        queue_unit(16'($urandom_range(HighLast, HighFirst)), 1'b0);
        queue_unit(16'($urandom_range(LowLast, LowFirst)), fin);
        pushed += 2;
      end else if (kind < 82) begin
        queue_unit(16'($urandom_range(HighLast, HighFirst)), fin);
        pushed++;
      end else if (kind < 88) begin
        queue_unit(16'($urandom_range(LowLast, LowFirst)), fin);
        pushed++;
      end else begin
        queue_unit(16'($urandom), fin);
        pushed++;
      end
    end
  endtask

  // Offer code units from the backlog, predict on each accepted beat
  always @(posedge clk_i) begin : drive_units
    bit took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        transcode_unit(utf16_backlog[0].unit, utf16_backlog[0].fin);
        void'(utf16_backlog.pop_front());
        units_taken <= units_taken + 1;
      end
      if (!in_valid_i || took) begin
        if (utf16_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid_i   <= 1'b1;
          code_unit_i  <= utf16_backlog[0].unit;
          final_unit_i <= utf16_backlog[0].fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Hold the output side off for a long stretch once the trigger count is hit
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && units_taken == hold_at) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each output beat against the oldest expected byte
  always @(posedge clk_i) begin : watch_bytes
    utf8_beat_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (utf8_expect.size() == 0) begin
          $error("unexpected output byte %02h", out_byte_o);
          err_cnt++;
        end else begin
          e = utf8_expect.pop_front();
          if (out_byte_o !== e.data) begin
            $error("out_byte: expected %02h, got %02h", e.data, out_byte_o);
            err_cnt++;
          end
          if (run_last_o !== e.run_last) begin
            $error("run_last: expected %0b, got %0b", e.run_last, run_last_o);
            err_cnt++;
          end
          if (string_end_o !== e.string_end) begin
            $error("string_end: expected %0b, got %0b", e.string_end, string_end_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (utf16_backlog.size() != 0 || utf8_expect.size() != 0);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Sender idles lightly, receiver heavily
    in_idle_pct  = 22;
    out_idle_pct = 61;
    queue_unit(16'h0000, 1'b1);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hD7FF, 1'b0);
    queue_unit(16'hE000, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
    // Well-formed pairs at both ends of the surrogate ranges
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    // Held high surrogate followed by a non-low unit
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'h0041, 1'b0);
    // Held high surrogate followed by another high, which then pairs
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hD83D, 1'b0);
    queue_unit(16'hDE00, 1'b1);
    // High surrogate as the last unit of a string
    queue_unit(16'hDABC, 1'b1);
    // Lone low surrogates
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    // Held high flushed by a final 3-byte unit, by a final high, then by a final 2-byte unit
    queue_unit(16'hD801, 1'b0);
    queue_unit(16'h0800, 1'b1);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDBFF, 1'b1);
    queue_unit(16'hDA00, 1'b0);
    queue_unit(16'h07FF, 1'b1);
    queue_random(108);
    wait_drained();

    // Sender idles heavily, receiver lightly
    in_idle_pct  = 61;
    out_idle_pct = 22;
    queue_random(108);
    wait_drained();

    // Full rate, with one long receiver hold-off
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_at      = units_taken + 20;
    queue_random(108);
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0 && utf8_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $error("timeout with %0d units and %0d bytes outstanding",
           utf16_backlog.size(), utf8_expect.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
